FILE: hw/rtl/efu_pkg.sv
package efu_pkg;

    // field widths
    localparam int X_W   = 16;
    localparam int ERF_W = 16;

    typedef logic signed [X_W-1:0]   x_value_t;
    typedef logic signed [ERF_W-1:0] erf_value_t;

    // shared arithmetic unit sizes
    localparam int MUL_A_W   = 48;
    localparam int MUL_B_W   = 32;
    localparam int MUL_H_W   = 24;
    localparam int PROD_W    = 80;
    localparam int DEN_W     = 42;
    localparam int DVD_W     = 63;
    localparam int DIV_STEPS = 36;

    // fixed-point constants
    localparam logic [31:0] LOG2E_Q30       = 32'd1549082005;
    localparam logic [31:0] LN2_Q30         = 32'd744261118;
    localparam logic [31:0] INV_SQRT_PI_Q30 = 32'd605793953;
    localparam logic [31:0] TOL_DEN         = 32'd10000000;
    localparam logic [30:0] SERIES_LIMIT    = 31'd25165824;
    localparam int          EXP_TERMS       = 13;
    localparam logic [41:0] ONE_Q31         = 42'h0_8000_0000;
    localparam logic [53:0] ONE_Q32         = 54'h1_0000_0000;
    localparam logic [79:0] TOL_LIMIT       = 80'h1_8000_0000;
    localparam logic [62:0] RECIP_NUM       = 63'h4000_0000_0000_0000;

endpackage

FILE: hw/rtl/efu_if.sv
// sample channel
interface efu_in_if;
    import efu_pkg::*;
    logic     valid;
    logic     ready;
    x_value_t x_value;
    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);
endinterface

// result channel
interface efu_out_if;
    import efu_pkg::*;
    logic       valid;
    logic       ready;
    erf_value_t erf_value;
    modport source (output valid, output erf_value, input ready);
    modport sink   (input valid, input erf_value, output ready);
endinterface

FILE: hw/rtl/error_function_unit_top.sv
// erf of a Q3.12 sample, one word at a time, through one shared 24x32 multiplier
// (low half then high half of operand a) and one shared restoring divider
// exp(-x^2) first, then the power series or the continued fraction, up to 100 terms,
// then scaling by 1/sqrt(pi), rounding and saturation of the result
// a new word is taken only in idle, once the previous result is in the output register
// reset: rst_n asynchronous active low, returns to idle with no result pending
module error_function_unit_top #(
    parameter int MAX_TERMS     = 100,
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    efu_in_if.sink     sample,
    efu_out_if.source  result
);
    import efu_pkg::*;

    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int AW = $clog2(2 * MAX_TERMS * MAX_TERMS + 1);
    localparam int SH = 32 - OUT_FRAC_BITS;
    localparam logic [33:0] RND  = 34'(1) << (31 - OUT_FRAC_BITS);
    localparam logic [33:0] MAXV = (34'(1) << OUT_FRAC_BITS) - 34'(1);

    typedef enum logic [30:0] {
        ST_IDLE     = 31'(1) << 0,
        ST_MUL_LO   = 31'(1) << 1,
        ST_MUL_HI   = 31'(1) << 2,
        ST_DIV_RUN  = 31'(1) << 3,
        ST_SQ       = 31'(1) << 4,
        ST_T        = 31'(1) << 5,
        ST_Y        = 31'(1) << 6,
        ST_EXP_LOOP = 31'(1) << 7,
        ST_EXP_DIV  = 31'(1) << 8,
        ST_EXP_ACC  = 31'(1) << 9,
        ST_EXP_END  = 31'(1) << 10,
        ST_SER_MUL  = 31'(1) << 11,
        ST_SER_DIV  = 31'(1) << 12,
        ST_SER_ACC  = 31'(1) << 13,
        ST_SER_CHK  = 31'(1) << 14,
        ST_FR_INIT  = 31'(1) << 15,
        ST_FR_H0    = 31'(1) << 16,
        ST_FR_IT    = 31'(1) << 17,
        ST_FR_D     = 31'(1) << 18,
        ST_FR_C     = 31'(1) << 19,
        ST_FR_CINV  = 31'(1) << 20,
        ST_FR_DINV  = 31'(1) << 21,
        ST_FR_DEL   = 31'(1) << 22,
        ST_FR_HM    = 31'(1) << 23,
        ST_FR_HU    = 31'(1) << 24,
        ST_FR_CHK   = 31'(1) << 25,
        ST_MANT     = 31'(1) << 26,
        ST_MANT_A   = 31'(1) << 27,
        ST_SC2      = 31'(1) << 28,
        ST_SC3      = 31'(1) << 29,
        ST_FIN      = 31'(1) << 30
    } state_t;

    // control registers
    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic   out_valid_reg, out_valid_next;
    logic [5:0] div_cnt_reg, div_cnt_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // datapath registers
    logic [MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic [MUL_B_W-1:0] mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DEN_W-1:0]   div_rem_reg, div_rem_next;
    logic [DIV_STEPS-1:0] div_q_reg, div_q_next;
    logic [DEN_W-1:0]   div_den_reg, div_den_next;
    logic        neg_reg, neg_next;
    logic        frac_reg, frac_next;
    logic [16:0] ax_reg, ax_next;
    logic [30:0] s_reg, s_next;
    logic [6:0]  k_reg, k_next;
    logic [29:0] y_reg, y_next;
    logic [30:0] term_reg, term_next;
    logic signed [32:0] acc_reg, acc_next;
    logic [31:0] e_reg, e_next;
    logic [41:0] del_reg, del_next;
    logic [36:0] sum_reg, sum_next;
    logic [41:0] b_reg, b_next;
    logic [41:0] d_reg, d_next;
    logic [41:0] c_reg, c_next;
    logic [31:0] d_inv_reg, d_inv_next;
    logic [31:0] c_inv_reg, c_inv_next;
    logic [31:0] h_reg, h_next;
    logic [AW-1:0] anx2_reg, anx2_next;
    logic [15:0] res_reg, res_next;
    logic [15:0] out_reg, out_next;

    // shared multiplier, low half then high half of operand a
    logic [MUL_H_W-1:0] mul_sel;
    logic [55:0]        mul_half;
    assign mul_sel  = (state_reg == ST_MUL_HI) ? mul_a_reg[47:24] : mul_a_reg[23:0];
    assign mul_half = mul_sel * mul_b_reg;

    // divider trial subtract
    logic [DEN_W:0] div_trial;
    logic           div_ge;
    assign div_trial = {div_rem_reg, div_q_reg[DIV_STEPS-1]};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};

    assign sample.ready     = (state_reg == ST_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.erf_value = out_reg;

    // sequencer
    always_comb
    begin
        logic               mul_go;
        logic [MUL_A_W-1:0] ma;
        logic [MUL_B_W-1:0] mb;
        logic               div_go;
        logic [DVD_W-1:0]   dvd;
        logic [DEN_W-1:0]   den;
        state_t             ret;
        logic [16:0]        axv;
        logic [31:0]        acc_cl;
        logic [38:0]        sum3;
        logic [41:0]        tmp;
        logic [48:0]        hn;
        logic [41:0]        diff;
        logic               more;
        logic [53:0]        qc;
        logic [33:0]        p;
        logic [33:0]        r;

        state_next     = state_reg;
        ret_next       = ret_reg;
        out_valid_next = out_valid_reg;
        div_cnt_next   = div_cnt_reg;
        cnt_next       = cnt_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        prod_next      = prod_reg;
        div_rem_next   = div_rem_reg;
        div_q_next     = div_q_reg;
        div_den_next   = div_den_reg;
        neg_next       = neg_reg;
        frac_next      = frac_reg;
        ax_next        = ax_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        y_next         = y_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        del_next       = del_reg;
        sum_next       = sum_reg;
        b_next         = b_reg;
        d_next         = d_reg;
        c_next         = c_reg;
        d_inv_next     = d_inv_reg;
        c_inv_next     = c_inv_reg;
        h_next         = h_reg;
        anx2_next      = anx2_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        mul_go = 1'b0;
        ma     = '0;
        mb     = '0;
        div_go = 1'b0;
        dvd    = '0;
        den    = '0;
        ret    = ST_IDLE;
        axv    = '0;
        acc_cl = '0;
        sum3   = '0;
        tmp    = '0;
        hn     = '0;
        diff   = '0;
        more   = 1'b0;
        qc     = '0;
        p      = '0;
        r      = '0;

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    neg_next = sample.x_value[15];
                    axv = sample.x_value[15] ? 17'h10000 - {1'b0, sample.x_value}
                                             : {1'b0, sample.x_value};
                    ax_next = axv;
                    mul_go = 1'b1;
                    ma = 48'(axv);
                    mb = 32'(axv);
                    ret = ST_SQ;
                end
            end
            ST_MUL_LO:
            begin
                prod_next  = 80'(mul_half);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                prod_next  = prod_reg + {mul_half, 24'b0};
                state_next = ret_reg;
            end
            ST_DIV_RUN:
            begin
                div_rem_next = div_ge ? DEN_W'(div_trial - {1'b0, div_den_reg})
                                      : div_trial[DEN_W-1:0];
                div_q_next   = {div_q_reg[DIV_STEPS-2:0], div_ge};
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = ret_reg;
                end
            end
            // exp(-s) argument reduction
            ST_SQ:
            begin
                s_next = prod_reg[30:0];
                mul_go = 1'b1;
                ma = 48'(prod_reg[30:0]);
                mb = LOG2E_Q30;
                ret = ST_T;
            end
            ST_T:
            begin
                k_next = prod_reg[60:54];
                mul_go = 1'b1;
                ma = 48'(prod_reg[53:30]);
                mb = LN2_Q30;
                ret = ST_Y;
            end
            ST_Y:
            begin
                y_next     = prod_reg[53:24];
                term_next  = 31'h4000_0000;
                acc_next   = 33'sh0_4000_0000;
                cnt_next   = CW'(1);
                state_next = ST_EXP_LOOP;
            end
            // taylor terms of exp(-y)
            ST_EXP_LOOP:
            begin
                mul_go = 1'b1;
                ma = 48'(term_reg);
                mb = 32'(y_reg);
                ret = ST_EXP_DIV;
            end
            ST_EXP_DIV:
            begin
                div_go = 1'b1;
                dvd = 63'(prod_reg[79:30]);
                den = 42'(cnt_reg);
                ret = ST_EXP_ACC;
            end
            ST_EXP_ACC:
            begin
                term_next = div_q_reg[30:0];
                if (cnt_reg[0])
                begin
                    acc_next = acc_reg - $signed({2'b00, div_q_reg[30:0]});
                end
                else
                begin
                    acc_next = acc_reg + $signed({2'b00, div_q_reg[30:0]});
                end
                if (cnt_reg == CW'(EXP_TERMS))
                begin
                    state_next = ST_EXP_END;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_EXP_LOOP;
                end
            end
            ST_EXP_END:
            begin
                acc_cl = acc_reg[32] ? 32'd0 : acc_reg[31:0];
                e_next = (k_reg >= 7'd31) ? 32'd0 : (acc_cl >> k_reg);
                if (s_reg < SERIES_LIMIT)
                begin
                    frac_next  = 1'b0;
                    del_next   = 42'h2_0000_0000;
                    sum_next   = 37'h2_0000_0000;
                    cnt_next   = CW'(1);
                    state_next = ST_SER_MUL;
                end
                else
                begin
                    frac_next  = 1'b1;
                    b_next     = {4'b0, s_reg, 7'b0} + 42'h0_4000_0000;
                    state_next = ST_FR_INIT;
                end
            end
            // power series
            ST_SER_MUL:
            begin
                mul_go = 1'b1;
                ma = 48'(del_reg);
                mb = 32'(s_reg);
                ret = ST_SER_DIV;
            end
            ST_SER_DIV:
            begin
                div_go = 1'b1;
                dvd = 63'(prod_reg[79:23]);
                den = 42'({cnt_reg, 1'b1});
                ret = ST_SER_ACC;
            end
            ST_SER_ACC:
            begin
                del_next = 42'(div_q_reg);
                sum_next = sum_reg + 37'(div_q_reg);
                mul_go = 1'b1;
                ma = 48'(div_q_reg);
                mb = TOL_DEN;
                ret = ST_SER_CHK;
            end
            ST_SER_CHK:
            begin
                sum3 = 39'(sum_reg) + 39'({sum_reg, 1'b0});
                if (prod_reg < 80'(sum3) || cnt_reg == CW'(MAX_TERMS))
                begin
                    state_next = ST_MANT;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_SER_MUL;
                end
            end
            // continued fraction
            ST_FR_INIT:
            begin
                tmp = (b_reg < ONE_Q31) ? ONE_Q31 : b_reg;
                d_next = tmp;
                div_go = 1'b1;
                dvd = RECIP_NUM;
                den = tmp;
                ret = ST_FR_H0;
            end
            ST_FR_H0:
            begin
                d_inv_next = div_q_reg[31:0];
                h_next     = div_q_reg[31:0];
                cnt_next   = CW'(1);
                anx2_next  = AW'(1);
                state_next = ST_FR_IT;
            end
            ST_FR_IT:
            begin
                b_next = b_reg + 42'h1_0000_0000;
                mul_go = 1'b1;
                ma = 48'(anx2_reg);
                mb = d_inv_reg;
                ret = ST_FR_D;
            end
            ST_FR_D:
            begin
                tmp = ({37'b0, b_reg} > prod_reg[79:1]) ? b_reg - prod_reg[42:1] : 42'd0;
                d_next = (tmp < ONE_Q31) ? ONE_Q31 : tmp;
                if (cnt_reg == CW'(1))
                begin
                    c_next     = (b_reg < ONE_Q31) ? ONE_Q31 : b_reg;
                    state_next = ST_FR_CINV;
                end
                else
                begin
                    mul_go = 1'b1;
                    ma = 48'(anx2_reg);
                    mb = c_inv_reg;
                    ret = ST_FR_C;
                end
            end
            ST_FR_C:
            begin
                tmp = ({37'b0, b_reg} > prod_reg[79:1]) ? b_reg - prod_reg[42:1] : 42'd0;
                c_next     = (tmp < ONE_Q31) ? ONE_Q31 : tmp;
                state_next = ST_FR_CINV;
            end
            ST_FR_CINV:
            begin
                div_go = 1'b1;
                dvd = RECIP_NUM;
                den = c_reg;
                ret = ST_FR_DINV;
            end
            ST_FR_DINV:
            begin
                c_inv_next = div_q_reg[31:0];
                div_go = 1'b1;
                dvd = RECIP_NUM;
                den = d_reg;
                ret = ST_FR_DEL;
            end
            ST_FR_DEL:
            begin
                d_inv_next = div_q_reg[31:0];
                mul_go = 1'b1;
                ma = 48'(c_reg);
                mb = div_q_reg[31:0];
                ret = ST_FR_HM;
            end
            ST_FR_HM:
            begin
                del_next = prod_reg[72:31];
                mul_go = 1'b1;
                ma = 48'(prod_reg[72:31]);
                mb = h_reg;
                ret = ST_FR_HU;
            end
            ST_FR_HU:
            begin
                hn = prod_reg[79:31];
                h_next = (hn > 49'(ONE_Q31)) ? 32'h8000_0000 : hn[31:0];
                diff = (del_reg > ONE_Q31) ? del_reg - ONE_Q31 : ONE_Q31 - del_reg;
                if (diff < ONE_Q31)
                begin
                    mul_go = 1'b1;
                    ma = 48'(diff);
                    mb = TOL_DEN;
                    ret = ST_FR_CHK;
                end
                else
                begin
                    more = 1'b1;
                end
            end
            ST_FR_CHK:
            begin
                if (prod_reg < TOL_LIMIT)
                begin
                    state_next = ST_MANT;
                end
                else
                begin
                    more = 1'b1;
                end
            end
            // mantissa and scaling by exp(-s) / sqrt(pi)
            ST_MANT:
            begin
                mul_go = 1'b1;
                ma = frac_reg ? 48'(h_reg) : 48'(sum_reg);
                mb = 32'(ax_reg);
                ret = ST_MANT_A;
            end
            ST_MANT_A:
            begin
                mul_go = 1'b1;
                ma = frac_reg ? prod_reg[62:15] : prod_reg[63:16];
                mb = e_reg;
                ret = ST_SC2;
            end
            ST_SC2:
            begin
                mul_go = 1'b1;
                ma = prod_reg[77:30];
                mb = INV_SQRT_PI_Q30;
                ret = ST_SC3;
            end
            ST_SC3:
            begin
                qc = (prod_reg[79:26] > ONE_Q32) ? ONE_Q32 : prod_reg[79:26];
                p  = frac_reg ? 34'(ONE_Q32 - qc) : 34'(qc);
                r  = (p + RND) >> SH;
                if (r > MAXV)
                begin
                    r = MAXV;
                end
                res_next   = neg_reg ? 16'(34'd0 - r) : r[15:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // next fraction step or finish
        if (more)
        begin
            if (cnt_reg == CW'(MAX_TERMS))
            begin
                state_next = ST_MANT;
            end
            else
            begin
                cnt_next   = cnt_reg + CW'(1);
                anx2_next  = anx2_reg + AW'({cnt_reg, 2'b01});
                state_next = ST_FR_IT;
            end
        end

        // launch shared multiplier
        if (mul_go)
        begin
            mul_a_next = ma;
            mul_b_next = mb;
            ret_next   = ret;
            state_next = ST_MUL_LO;
        end

        // launch shared divider
        if (div_go)
        begin
            div_rem_next = DEN_W'(dvd[DVD_W-1:DIV_STEPS]);
            div_q_next   = dvd[DIV_STEPS-1:0];
            div_den_next = den;
            div_cnt_next = 6'd0;
            ret_next     = ret;
            state_next   = ST_DIV_RUN;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        prod_reg    <= prod_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        div_den_reg <= div_den_next;
        neg_reg     <= neg_next;
        frac_reg    <= frac_next;
        ax_reg      <= ax_next;
        s_reg       <= s_next;
        k_reg       <= k_next;
        y_reg       <= y_next;
        term_reg    <= term_next;
        acc_reg     <= acc_next;
        e_reg       <= e_next;
        del_reg     <= del_next;
        sum_reg     <= sum_next;
        b_reg       <= b_next;
        d_reg       <= d_next;
        c_reg       <= c_next;
        d_inv_reg   <= d_inv_next;
        c_inv_reg   <= c_inv_next;
        h_reg       <= h_next;
        anx2_reg    <= anx2_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

endmodule
